// ===== hw/rtl/cbcr_pkg.sv =====
`default_nettype none

package cbcr_pkg;

   localparam int PC_BITS   = 16;
   localparam int BYTE_BITS = 8;
   localparam int KIND_BITS = 3;
   localparam int COND_BITS = 3;
   localparam int RST_BITS  = 3;
   localparam int RST_SHIFT = 3;

   localparam logic [PC_BITS-1:0] CALL_LEN = 16'd3;
   localparam logic [PC_BITS-1:0] RST_LEN  = 16'd1;
   localparam logic [PC_BITS-1:0] WORD_LEN = 16'd2;
   localparam logic [PC_BITS-1:0] ONE      = 16'd1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_JMP   = 3'd0,
      KIND_JCOND = 3'd1,
      KIND_CALL  = 3'd2,
      KIND_CALLC = 3'd3,
      KIND_RET   = 3'd4,
      KIND_RETC  = 3'd5,
      KIND_RST   = 3'd6,
      KIND_PCHL  = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      FLAG_ZERO   = 2'd0,
      FLAG_CARRY  = 2'd1,
      FLAG_PARITY = 2'd2,
      FLAG_SIGN   = 2'd3
   } flag_sel_type;

   // even codes test for clear, odd codes for set
   function automatic logic cond_met(input logic [COND_BITS-1:0] code,
                                     input logic z, input logic c,
                                     input logic p, input logic s);
      logic flag;
      case (flag_sel_type'(code[2:1]))
         FLAG_ZERO:   flag = z;
         FLAG_CARRY:  flag = c;
         FLAG_PARITY: flag = p;
         default:     flag = s;
      endcase
      return flag == code[0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbcr_req_if.sv =====
`default_nettype none

interface cbcr_req_if;
   logic                               valid;
   logic                               ready;
   logic [cbcr_pkg::KIND_BITS-1:0]     req_type;
   logic [cbcr_pkg::COND_BITS-1:0]     cond_code;
   logic [cbcr_pkg::PC_BITS-1:0]       target_addr;
   logic [cbcr_pkg::RST_BITS-1:0]      restart_num;
   logic [cbcr_pkg::PC_BITS-1:0]       cur_pc;
   logic                               flag_zero;
   logic                               flag_carry;
   logic                               flag_parity;
   logic                               flag_sign;
   logic [cbcr_pkg::PC_BITS-1:0]       hl_value;

   modport source (output valid, req_type, cond_code, target_addr, restart_num, cur_pc,
                   flag_zero, flag_carry, flag_parity, flag_sign, hl_value,
                   input ready);
   modport sink (input valid, req_type, cond_code, target_addr, restart_num, cur_pc,
                 flag_zero, flag_carry, flag_parity, flag_sign, hl_value,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cbcr_rsp_if.sv =====
`default_nettype none

interface cbcr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cbcr_pkg::PC_BITS-1:0]   next_pc;
   logic [cbcr_pkg::PC_BITS-1:0]   stack_ptr;
   logic                           taken;

   modport source (output valid, next_pc, stack_ptr, taken, input ready);
   modport sink (input valid, next_pc, stack_ptr, taken, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cond_branch_call_return_unit.sv =====
// Branch, call and return unit of an 8-bit processor.
// req carries one instruction word per handshake (valid and ready high at a
// rising edge): kind, condition code, immediate target, restart vector,
// current PC, the four flags and HL. rsp returns one word per instruction:
// next PC, stack pointer after the instruction and the taken bit.
// Return addresses live in a byte-wide single-port stack RAM of
// 2^ADDR_BITS entries with registered read data; SP wraps modulo 2^16 and
// addresses it modulo the RAM size.
// Jumps, untaken conditionals and jump-to-HL finish in the accept cycle:
// the result goes to the output register, one word per cycle while it is free.
// Calls and restarts write the high byte in the accept cycle and the low
// byte from ST_PUSH_LO once the output register is free. Returns read the
// low byte, then the high byte, then assemble. The single RAM port makes
// these byte accesses run one after another.
// The result sits in an output register. A new word is accepted only with
// no stack access in flight and with the output register empty or read in
// the same cycle, so a stalled receiver holds the result and blocks req.
// Synchronous reset clears SP to zero and empties the output register; the
// stack RAM is not cleared.
`default_nettype none

module cond_branch_call_return_unit #(
   parameter int ADDR_BITS = 16
) (
   input wire logic    clock,
   input wire logic    reset,
   cbcr_req_if.sink    req,
   cbcr_rsp_if.source  rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_LO,
      ST_POP_HI,
      ST_POP_DONE
   } state_type;

   localparam int PB = cbcr_pkg::PC_BITS;
   localparam int BB = cbcr_pkg::BYTE_BITS;

   state_type         state_ff;
   logic [PB-1:0]     sp_ff;
   logic [PB-1:0]     npc_ff;
   logic [BB-1:0]     push_lo_ff;
   logic [BB-1:0]     pop_lo_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PB-1:0]     next_pc_ff;
   logic [PB-1:0]     stack_ptr_ff;
   logic              taken_ff;

   cbcr_pkg::kind_type kind;
   logic              met;
   logic              do_push;
   logic              do_pop;
   logic              out_free;
   logic              accept;
   logic              word_done;
   logic [PB-1:0]     pc_call;
   logic [PB-1:0]     pc_rst;
   logic [PB-1:0]     rst_target;
   logic [PB-1:0]     push_val;
   logic [PB-1:0]     push_pc;
   logic [PB-1:0]     imm_pc;
   logic              imm_taken;
   logic [PB-1:0]     mem_addr;
   logic              mem_wr;
   logic              mem_rd;
   logic [BB-1:0]     mem_wdata;
   logic [BB-1:0]     mem_rdata;

   assign kind       = cbcr_pkg::kind_type'(req.req_type);
   assign met        = cbcr_pkg::cond_met(req.cond_code, req.flag_zero, req.flag_carry,
                                          req.flag_parity, req.flag_sign);
   assign pc_call    = req.cur_pc + cbcr_pkg::CALL_LEN;
   assign pc_rst     = req.cur_pc + cbcr_pkg::RST_LEN;
   assign rst_target = PB'(req.restart_num) << cbcr_pkg::RST_SHIFT;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req.valid && req.ready;

   assign word_done    = ((state_ff == ST_IDLE) && accept && !do_push && !do_pop) ||
                         (((state_ff == ST_PUSH_LO) || (state_ff == ST_POP_DONE)) &&
                          out_free);
   assign rsp_valid_in = word_done || (rsp_valid_ff && !rsp.ready);

   always_comb begin
      do_push   = 1'b0;
      do_pop    = 1'b0;
      push_val  = pc_call;
      push_pc   = req.target_addr;
      imm_pc    = req.target_addr;
      imm_taken = 1'b1;
      case (kind)
         cbcr_pkg::KIND_JMP: begin
            imm_pc = req.target_addr;
         end
         cbcr_pkg::KIND_JCOND: begin
            imm_taken = met;
            imm_pc    = met ? req.target_addr : pc_call;
         end
         cbcr_pkg::KIND_CALL: begin
            do_push = 1'b1;
         end
         cbcr_pkg::KIND_CALLC: begin
            do_push   = met;
            imm_taken = met;
            imm_pc    = pc_call;
         end
         cbcr_pkg::KIND_RET: begin
            do_pop = 1'b1;
         end
         cbcr_pkg::KIND_RETC: begin
            do_pop    = met;
            imm_taken = met;
            imm_pc    = pc_rst;
         end
         cbcr_pkg::KIND_RST: begin
            do_push  = 1'b1;
            push_val = pc_rst;
            push_pc  = rst_target;
         end
         default: begin
            imm_pc = req.hl_value;
         end
      endcase
   end

   always_comb begin
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      mem_addr  = sp_ff;
      mem_wdata = push_val[PB-1:BB];
      case (state_ff)
         ST_IDLE: begin
            mem_wr   = accept && do_push;
            mem_rd   = accept && do_pop;
            mem_addr = do_push ? (sp_ff - cbcr_pkg::ONE) : sp_ff;
         end
         ST_PUSH_LO: begin
            mem_wr    = out_free;
            mem_addr  = sp_ff - cbcr_pkg::WORD_LEN;
            mem_wdata = push_lo_ff;
         end
         ST_POP_HI: begin
            mem_rd   = 1'b1;
            mem_addr = sp_ff + cbcr_pkg::ONE;
         end
         default: begin
            mem_addr = sp_ff;
         end
      endcase
   end

   cbcr_stack_ram #(
      .ADDR_BITS (ADDR_BITS)
   ) u_stack_ram (
      .clock (clock),
      .wr_en (mem_wr),
      .rd_en (mem_rd),
      .addr  (mem_addr[ADDR_BITS-1:0]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (do_push) begin
                     push_lo_ff <= push_val[BB-1:0];
                     npc_ff     <= push_pc;
                     state_ff   <= ST_PUSH_LO;
                  end else if (do_pop) begin
                     state_ff <= ST_POP_HI;
                  end else begin
                     next_pc_ff   <= imm_pc;
                     stack_ptr_ff <= sp_ff;
                     taken_ff     <= imm_taken;
                  end
               end
            end
            ST_PUSH_LO: begin
               if (out_free) begin
                  sp_ff        <= sp_ff - cbcr_pkg::WORD_LEN;
                  next_pc_ff   <= npc_ff;
                  stack_ptr_ff <= sp_ff - cbcr_pkg::WORD_LEN;
                  taken_ff     <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_POP_HI: begin
               pop_lo_ff <= mem_rdata;
               state_ff  <= ST_POP_DONE;
            end
            default: begin
               if (out_free) begin
                  sp_ff        <= sp_ff + cbcr_pkg::WORD_LEN;
                  next_pc_ff   <= {mem_rdata, pop_lo_ff};
                  stack_ptr_ff <= sp_ff + cbcr_pkg::WORD_LEN;
                  taken_ff     <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.next_pc   = next_pc_ff;
   assign rsp.stack_ptr = stack_ptr_ff;
   assign rsp.taken     = taken_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cbcr_stack_ram.sv =====
`default_nettype none

module cbcr_stack_ram #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic                            rd_en,
   input  wire logic [ADDR_BITS-1:0]            addr,
   input  wire logic [cbcr_pkg::BYTE_BITS-1:0]  wdata,
   output logic      [cbcr_pkg::BYTE_BITS-1:0]  rdata
);

   logic [cbcr_pkg::BYTE_BITS-1:0] mem [(1 << ADDR_BITS)];
   logic [cbcr_pkg::BYTE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
